[rtl/edfsd_pkg.sv]
// ----------------------------------------------------------------------------
// edfsd_pkg
// Shared types and constants of the earliest-deadline-first scheduler with
// drop: result outcome codes, controller commands and datapath status.
// ----------------------------------------------------------------------------
package edfsd_pkg;

  // field widths of the request and result items
  localparam int unsigned ID_W   = 16;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned BURST_W = 16;

  // results one tick may give before it stops dropping
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  // result outcome codes
  typedef enum logic [1:0] {
    OUT_DROPPED   = 2'd0,
    OUT_COMPLETED = 2'd1,
    OUT_REJECTED  = 2'd2
  } outcome_e;

  // request type codes
  localparam logic REQ_ARRIVE = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic     accept;      // latch request, restart free-slot search
    logic     free_inc;    // next slot in free-slot search
    logic     free_write;  // store job in the free slot
    logic     scan_start;  // start an earliest-deadline pass
    logic     cnt_clr;     // clear per-tick result count
    logic     cnt_inc;     // count one result
    logic     slot_clr;    // remove the picked job
    logic     run_write;   // run the picked job one unit
    logic     emit;        // new result into the hold stage
    outcome_e emit_kind;
    logic     flush;       // hold stage to output as final result
    logic     time_inc;    // advance time
  } edfsd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic item_tick;
    logic free_hit;
    logic free_last;
    logic scan_busy;
    logic best_found;
    logic cap_hit;
    logic infeasible;
    logic completes;
    logic emit_ok;
    logic flush_ok;
  } edfsd_sts_t;

endpackage

[rtl/edfsd_ifs.sv]
// ----------------------------------------------------------------------------
// edfsd request and result channels
// Valid/ready channels carrying one request item and one result item.
// ----------------------------------------------------------------------------

// request channel
interface edfsd_req_if import edfsd_pkg::*;;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [ID_W-1:0]    job_id;
  logic [TIME_W-1:0]  job_deadline;
  logic [BURST_W-1:0] job_burst;

  modport source (output valid, output req_type, output job_id, output job_deadline,
                  output job_burst, input ready);
  modport sink (input valid, input req_type, input job_id, input job_deadline,
                input job_burst, output ready);
endinterface

// result channel
interface edfsd_res_if import edfsd_pkg::*;;
  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   res_id;
  outcome_e          outcome;
  logic [TIME_W-1:0] event_time;
  logic [TIME_W-1:0] turnaround;
  logic [TIME_W-1:0] wait_time;
  logic              last;

  modport source (output valid, output res_id, output outcome, output event_time,
                  output turnaround, output wait_time, output last, input ready);
  modport sink (input valid, input res_id, input outcome, input event_time,
                input turnaround, input wait_time, input last, output ready);
endinterface

[rtl/edfsd_dp.sv]
// ----------------------------------------------------------------------------
// edfsd_dp
// Datapath: job table memories, slot valid bits, time counter, free-slot
// search, earliest-deadline scan, feasibility check and result staging.
// ----------------------------------------------------------------------------
module edfsd_dp import edfsd_pkg::*; #(
  parameter int unsigned JOB_SLOTS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  edfsd_cmd_t         cmd_i,
  output edfsd_sts_t         sts_o,
  input  logic               req_type_i,
  input  logic [ID_W-1:0]    job_id_i,
  input  logic [TIME_W-1:0]  job_deadline_i,
  input  logic [BURST_W-1:0] job_burst_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output logic [ID_W-1:0]    res_id_o,
  output outcome_e           res_outcome_o,
  output logic [TIME_W-1:0]  res_event_time_o,
  output logic [TIME_W-1:0]  res_turnaround_o,
  output logic [TIME_W-1:0]  res_wait_time_o,
  output logic               res_last_o
);

  localparam int unsigned IdxW = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(JOB_SLOTS - 1);

  // job table
  logic [ID_W-1:0]    mem_id    [JOB_SLOTS];
  logic [TIME_W-1:0]  mem_dl    [JOB_SLOTS];
  logic [BURST_W-1:0] mem_rem   [JOB_SLOTS];
  logic [BURST_W-1:0] mem_burst [JOB_SLOTS];
  logic [TIME_W-1:0]  mem_arr   [JOB_SLOTS];
  logic [JOB_SLOTS-1:0] valid_q;

  // latched request
  logic               item_tick_q;
  logic [ID_W-1:0]    item_id_q;
  logic [TIME_W-1:0]  item_dl_q;
  logic [BURST_W-1:0] item_burst_q;

  logic [TIME_W-1:0]    now_q;
  logic [RES_CNT_W-1:0] res_cnt_q;
  logic [IdxW-1:0]      free_idx_q;

  // scan state
  logic            scan_act_q;
  logic [IdxW-1:0] rd_idx_q;
  logic            cmp_vld_q;
  logic [IdxW-1:0] cmp_idx_q;
  logic            best_found_q;
  logic [IdxW-1:0] best_idx_q;
  logic [TIME_W-1:0] best_dl_q;
  logic [TIME_W-1:0] best_arr_q;

  // registered read data
  logic [IdxW-1:0]    rd_addr;
  logic [ID_W-1:0]    rd_id_q;
  logic [TIME_W-1:0]  rd_dl_q;
  logic [BURST_W-1:0] rd_rem_q;
  logic [BURST_W-1:0] rd_burst_q;
  logic [TIME_W-1:0]  rd_arr_q;

  logic [TIME_W-1:0] ta_q;
  logic [TIME_W-1:0] wt_q;

  // hold stage and output register
  logic              hold_vld_q;
  logic [ID_W-1:0]   hold_id_q;
  outcome_e          hold_oc_q;
  logic [TIME_W-1:0] hold_time_q;
  logic [TIME_W-1:0] hold_ta_q;
  logic [TIME_W-1:0] hold_wt_q;
  logic              out_vld_q;
  logic [ID_W-1:0]   out_id_q;
  outcome_e          out_oc_q;
  logic [TIME_W-1:0] out_time_q;
  logic [TIME_W-1:0] out_ta_q;
  logic [TIME_W-1:0] out_wt_q;
  logic              out_last_q;

  logic               better;
  logic [TIME_W:0]    slack;
  logic [BURST_W-1:0] rem_next;
  logic               rem_we;
  logic [IdxW-1:0]    rem_waddr;
  logic [BURST_W-1:0] rem_wdata;
  logic               out_room;
  logic               out_load;
  logic [ID_W-1:0]    new_id;
  logic [TIME_W-1:0]  new_ta;
  logic [TIME_W-1:0]  new_wt;

  // request latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_tick_q  <= req_type_i;
      item_id_q    <= job_id_i;
      item_dl_q    <= job_deadline_i;
      item_burst_q <= job_burst_i;
    end
  end

  // time, result count, free-slot pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q      <= '0;
      res_cnt_q  <= '0;
      free_idx_q <= '0;
    end else begin
      if (cmd_i.time_inc) now_q <= now_q + TIME_W'(1);
      if (cmd_i.cnt_clr) res_cnt_q <= '0;
      else if (cmd_i.cnt_inc) res_cnt_q <= res_cnt_q + RES_CNT_W'(1);
      if (cmd_i.accept) free_idx_q <= '0;
      else if (cmd_i.free_inc) free_idx_q <= free_idx_q + IdxW'(1);
    end
  end

  // slot valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (cmd_i.free_write) valid_q[free_idx_q] <= 1'b1;
      if (cmd_i.slot_clr) valid_q[best_idx_q] <= 1'b0;
    end
  end

  // table writes
  assign rem_next  = (rd_rem_q == '0) ? '0 : rd_rem_q - BURST_W'(1);
  assign rem_we    = cmd_i.free_write | cmd_i.run_write;
  assign rem_waddr = cmd_i.run_write ? best_idx_q : free_idx_q;
  assign rem_wdata = cmd_i.run_write ? rem_next : item_burst_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.free_write) begin
      mem_id[free_idx_q]    <= item_id_q;
      mem_dl[free_idx_q]    <= item_dl_q;
      mem_burst[free_idx_q] <= item_burst_q;
      mem_arr[free_idx_q]   <= now_q;
    end
    if (rem_we) mem_rem[rem_waddr] <= rem_wdata;
  end

  // table reads
  assign rd_addr = scan_act_q ? rd_idx_q : best_idx_q;

  always_ff @(posedge clk_i) begin
    rd_id_q    <= mem_id[rd_addr];
    rd_dl_q    <= mem_dl[rd_addr];
    rd_rem_q   <= mem_rem[rd_addr];
    rd_burst_q <= mem_burst[rd_addr];
    rd_arr_q   <= mem_arr[rd_addr];
  end

  // earliest deadline, then earliest arrival, then lowest slot
  assign better = cmp_vld_q && valid_q[cmp_idx_q] &&
                  (!best_found_q || (rd_dl_q < best_dl_q) ||
                   ((rd_dl_q == best_dl_q) && (rd_arr_q < best_arr_q)));

  // scan sequencer, one slot read per cycle, compare in the cycle after the read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_act_q   <= 1'b0;
      rd_idx_q     <= '0;
      cmp_vld_q    <= 1'b0;
      cmp_idx_q    <= '0;
      best_found_q <= 1'b0;
      best_idx_q   <= '0;
    end else if (cmd_i.scan_start) begin
      scan_act_q   <= 1'b1;
      rd_idx_q     <= '0;
      cmp_vld_q    <= 1'b0;
      best_found_q <= 1'b0;
    end else begin
      cmp_vld_q <= scan_act_q;
      cmp_idx_q <= rd_idx_q;
      if (scan_act_q) begin
        rd_idx_q <= rd_idx_q + IdxW'(1);
        if (rd_idx_q == LastIdx) scan_act_q <= 1'b0;
      end
      if (better) begin
        best_found_q <= 1'b1;
        best_idx_q   <= cmp_idx_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (better) begin
      best_dl_q  <= rd_dl_q;
      best_arr_q <= rd_arr_q;
    end
  end

  // feasibility: deadline minus now must exceed remaining burst
  assign slack = {1'b0, rd_dl_q} - {1'b0, now_q};

  // turnaround, then waiting time
  always_ff @(posedge clk_i) begin
    ta_q <= now_q + TIME_W'(1) - rd_arr_q;
    wt_q <= (ta_q >= TIME_W'(rd_burst_q)) ? ta_q - TIME_W'(rd_burst_q) : '0;
  end

  // new result record
  assign new_id = (cmd_i.emit_kind == OUT_REJECTED) ? item_id_q : rd_id_q;
  assign new_ta = (cmd_i.emit_kind == OUT_COMPLETED) ? ta_q : '0;
  assign new_wt = (cmd_i.emit_kind == OUT_COMPLETED) ? wt_q : '0;

  assign out_room = !out_vld_q || res_ready_i;
  assign out_load = (cmd_i.emit || cmd_i.flush) && hold_vld_q;

  // hold stage keeps the newest result until its last flag is known
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_vld_q <= 1'b0;
    end else if (cmd_i.emit) begin
      hold_vld_q <= 1'b1;
    end else if (cmd_i.flush) begin
      hold_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      hold_id_q   <= new_id;
      hold_oc_q   <= cmd_i.emit_kind;
      hold_time_q <= now_q;
      hold_ta_q   <= new_ta;
      hold_wt_q   <= new_wt;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (res_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_id_q   <= hold_id_q;
      out_oc_q   <= hold_oc_q;
      out_time_q <= hold_time_q;
      out_ta_q   <= hold_ta_q;
      out_wt_q   <= hold_wt_q;
      out_last_q <= cmd_i.flush;
    end
  end

  assign res_valid_o      = out_vld_q;
  assign res_id_o         = out_id_q;
  assign res_outcome_o    = out_oc_q;
  assign res_event_time_o = out_time_q;
  assign res_turnaround_o = out_ta_q;
  assign res_wait_time_o  = out_wt_q;
  assign res_last_o       = out_last_q;

  // status to controller
  always_comb begin
    sts_o            = '0;
    sts_o.item_tick  = (item_tick_q == REQ_TICK);
    sts_o.free_hit   = !valid_q[free_idx_q];
    sts_o.free_last  = (free_idx_q == LastIdx);
    sts_o.scan_busy  = scan_act_q | cmp_vld_q;
    sts_o.best_found = best_found_q;
    sts_o.cap_hit    = (res_cnt_q >= RES_CNT_W'(MAX_RESULTS));
    sts_o.infeasible = slack[TIME_W] || (slack[TIME_W-1:0] <= TIME_W'(rd_rem_q));
    sts_o.completes  = (rd_rem_q <= BURST_W'(1));
    sts_o.emit_ok    = !hold_vld_q || out_room;
    sts_o.flush_ok   = !hold_vld_q || out_room;
  end

endmodule

[rtl/edfsd_ctrl.sv]
// ----------------------------------------------------------------------------
// edfsd_ctrl
// Controller: sequences arrivals (free-slot search) and ticks (repeated
// earliest-deadline scans, drops, one run step, completion) over the datapath.
// ----------------------------------------------------------------------------
module edfsd_ctrl import edfsd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  edfsd_sts_t sts_i,
  output edfsd_cmd_t cmd_o
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DECODE = 4'd1;
  localparam logic [3:0] ST_FREE   = 4'd2;
  localparam logic [3:0] ST_REJ    = 4'd3;
  localparam logic [3:0] ST_SCAN   = 4'd4;
  localparam logic [3:0] ST_FETCH  = 4'd5;
  localparam logic [3:0] ST_EVAL   = 4'd6;
  localparam logic [3:0] ST_DROP   = 4'd7;
  localparam logic [3:0] ST_CALC   = 4'd8;
  localparam logic [3:0] ST_CMP    = 4'd9;
  localparam logic [3:0] ST_FLUSH  = 4'd10;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign req_ready_o = (state_q == ST_IDLE);

  // next state and commands
  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.emit_kind = OUT_DROPPED;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts_i.item_tick) begin
          cmd_o.scan_start = 1'b1;
          cmd_o.cnt_clr    = 1'b1;
          state_d          = ST_SCAN;
        end else begin
          state_d = ST_FREE;
        end
      end
      // lowest free slot, one slot a cycle
      ST_FREE: begin
        if (sts_i.free_hit) begin
          cmd_o.free_write = 1'b1;
          state_d          = ST_IDLE;
        end else if (sts_i.free_last) begin
          state_d = ST_REJ;
        end else begin
          cmd_o.free_inc = 1'b1;
        end
      end
      ST_REJ: begin
        if (sts_i.emit_ok) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = OUT_REJECTED;
          state_d         = ST_FLUSH;
        end
      end
      ST_SCAN: begin
        if (!sts_i.scan_busy) state_d = ST_FETCH;
      end
      ST_FETCH: begin
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (!sts_i.best_found || sts_i.cap_hit) begin
          state_d = ST_FLUSH;
        end else if (sts_i.infeasible) begin
          state_d = ST_DROP;
        end else begin
          cmd_o.run_write = 1'b1;
          state_d         = sts_i.completes ? ST_CALC : ST_FLUSH;
        end
      end
      // drop the picked job and look again
      ST_DROP: begin
        if (sts_i.emit_ok) begin
          cmd_o.emit       = 1'b1;
          cmd_o.emit_kind  = OUT_DROPPED;
          cmd_o.slot_clr   = 1'b1;
          cmd_o.cnt_inc    = 1'b1;
          cmd_o.scan_start = 1'b1;
          state_d          = ST_SCAN;
        end
      end
      ST_CALC: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (sts_i.emit_ok) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = OUT_COMPLETED;
          cmd_o.slot_clr  = 1'b1;
          cmd_o.cnt_inc   = 1'b1;
          state_d         = ST_FLUSH;
        end
      end
      // mark the last result, advance time on a tick
      ST_FLUSH: begin
        if (sts_i.flush_ok) begin
          cmd_o.flush    = 1'b1;
          cmd_o.time_inc = sts_i.item_tick;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/edf_scheduler_with_drop_top.sv]
// ----------------------------------------------------------------------------
// edf_scheduler_with_drop_top
// Earliest-deadline-first job scheduler that drops jobs which can no longer
// meet their deadline.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one request per handshake: an arrival (job id, absolute
//   deadline, burst) or a time tick. res_o carries results: dropped,
//   completed (with turnaround and waiting time) or rejected when the table
//   is full. The last flag marks the final result of a request; an accepted
//   arrival and a tick on an empty table give no result.
//   One request is worked on at a time; ready is high only while idle.
//   An arrival runs the free-slot search over the slot valid bits. A tick
//   runs one earliest-deadline scan per drop and a final scan with a run
//   step; the scan reads one job table entry per cycle.
//   Results pass through a hold stage and an output register, so the next
//   request is taken while the final result still waits; a stalled receiver
//   holds the block only when a new result needs the output register.
//   Reset clears the valid bits of all slots and sets time to zero; the
//   table entries themselves are not cleared.
// ----------------------------------------------------------------------------
module edf_scheduler_with_drop_top import edfsd_pkg::*; #(
  parameter int unsigned JOB_SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  edfsd_req_if.sink   req_i,
  edfsd_res_if.source res_o
);

  edfsd_cmd_t cmd;
  edfsd_sts_t sts;

  // sequencing
  edfsd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // job table and result path
  edfsd_dp #(
    .JOB_SLOTS (JOB_SLOTS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .req_type_i       (req_i.req_type),
    .job_id_i         (req_i.job_id),
    .job_deadline_i   (req_i.job_deadline),
    .job_burst_i      (req_i.job_burst),
    .res_valid_o      (res_o.valid),
    .res_ready_i      (res_o.ready),
    .res_id_o         (res_o.res_id),
    .res_outcome_o    (res_o.outcome),
    .res_event_time_o (res_o.event_time),
    .res_turnaround_o (res_o.turnaround),
    .res_wait_time_o  (res_o.wait_time),
    .res_last_o       (res_o.last)
  );

endmodule

[rtl/edfsd_checker.sv]
// ----------------------------------------------------------------------------
// edfsd_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module edfsd_checker import edfsd_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_valid_i,
  input logic              req_ready_i,
  input logic              res_valid_i,
  input logic              res_ready_i,
  input outcome_e          res_outcome_i,
  input logic [TIME_W-1:0] res_turnaround_i,
  input logic [TIME_W-1:0] res_wait_time_i,
  input logic              res_last_i
);

  // a stalled result stays offered
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result withdrawn while stalled");

  // one request at a time
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while busy");

  // a rejection is the only result of its request
  a_rej_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_outcome_i == OUT_REJECTED) |-> res_last_i)
    else $error("rejection without last flag");

  // only completions carry times
  a_times_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_outcome_i != OUT_COMPLETED) |->
      (res_turnaround_i == '0) && (res_wait_time_i == '0))
    else $error("times on a non-completion result");

  // waiting never exceeds turnaround
  a_wait_le_ta: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_outcome_i == OUT_COMPLETED) |->
      (res_wait_time_i <= res_turnaround_i))
    else $error("waiting time above turnaround");

endmodule

bind edf_scheduler_with_drop_top edfsd_checker u_edfsd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .res_valid_i      (res_o.valid),
  .res_ready_i      (res_o.ready),
  .res_outcome_i    (res_o.outcome),
  .res_turnaround_i (res_o.turnaround),
  .res_wait_time_i  (res_o.wait_time),
  .res_last_i       (res_o.last)
);

[bench/edf_scheduler_with_drop_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// edf_scheduler_with_drop_top_test
// Self-checking bench for the earliest-deadline-first scheduler. A directed
// walk covers a tick on an empty table, late and zero-burst jobs, a full
// table and a mass drop. Randomized arrivals and ticks follow, with random
// gaps, receiver stalls, one long receiver hold-off and one full drain.
// Every result is checked field by field against the in-bench model or a typed result.
// ----------------------------------------------------------------------------
module edf_scheduler_with_drop_top_test;
  import edfsd_pkg::*;

  localparam int unsigned JOB_SLOTS    = 16;
  localparam int unsigned RAND_ITEMS   = 204;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned HOLD_CYCLES  = 400;

  // one expected result
  typedef struct {
    logic [ID_W-1:0]   id;
    outcome_e          outcome;
    logic [TIME_W-1:0] event_time;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] wait_time;
    logic              last;
  } sched_result_t;

  // one directed request, optionally with its result written out by hand
  typedef struct {
    logic               req_type;
    logic [ID_W-1:0]    id;
    logic [TIME_W-1:0]  due;
    logic [BURST_W-1:0] len;
    bit                 typed;
    int                 exp_n;
    logic [ID_W-1:0]    exp_id;
    outcome_e           exp_outcome;
    logic [TIME_W-1:0]  exp_time;
  } step_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  edfsd_req_if req_bus ();
  edfsd_res_if res_bus ();

  edf_scheduler_with_drop_top #(.JOB_SLOTS(JOB_SLOTS)) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus.sink),
    .res_o (res_bus.source)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // scheduler model state
  logic               job_live    [JOB_SLOTS];
  logic [ID_W-1:0]    job_ident   [JOB_SLOTS];
  logic [TIME_W-1:0]  job_due     [JOB_SLOTS];
  logic [BURST_W-1:0] job_left    [JOB_SLOTS];
  logic [BURST_W-1:0] job_len     [JOB_SLOTS];
  logic [TIME_W-1:0]  job_arrived [JOB_SLOTS];
  logic [TIME_W-1:0]  sched_now;
  sched_result_t      pending_results [$];

  step_row_t   directed_steps [$];
  int unsigned error_count = 0;
  int unsigned gap_pct     = 13;
  int unsigned stall_pct   = 13;
  bit          hold_request = 1'b0;

  // earliest deadline, earlier arrival on a tie, lower slot after that
  function automatic int earliest_job();
    int best;
    best = -1;
    for (int i = 0; i < JOB_SLOTS; i++) begin
      if (job_live[i] && (best < 0 || job_due[i] < job_due[best] ||
          (job_due[i] == job_due[best] && job_arrived[i] < job_arrived[best])))
        best = i;
    end
    return best;
  endfunction

  function automatic void add_result(logic [ID_W-1:0] id, outcome_e outcome,
                                     logic [TIME_W-1:0] ta, logic [TIME_W-1:0] wt);
    sched_result_t r;
    r.id         = id;
    r.outcome    = outcome;
    r.event_time = sched_now;
    r.turnaround = ta;
    r.wait_time  = wt;
    r.last       = 1'b0;
    pending_results = {pending_results, r};
  endfunction

  // apply one request to the model, queue its results, return their count
  function automatic int schedule_step(logic req_type, logic [ID_W-1:0] id,
                                       logic [TIME_W-1:0] due, logic [BURST_W-1:0] len);
    int                n;
    int                j;
    logic [TIME_W-1:0] ta;
    logic [TIME_W-1:0] burst;
    n = 0;
    // arrival into the lowest free slot, rejected when none is free
    if (req_type == REQ_ARRIVE) begin
      for (int i = 0; i < JOB_SLOTS; i++) begin
        if (!job_live[i]) begin
          job_live[i]    = 1'b1;
          job_ident[i]   = id;
          job_due[i]     = due;
          job_left[i]    = len;
          job_len[i]     = len;
          job_arrived[i] = sched_now;
          return 0;
        end
      end
      add_result(id, OUT_REJECTED, '0, '0);
      pending_results[pending_results.size() - 1].last = 1'b1;
      return 1;
    end
    // tick: drop infeasible jobs, then run the earliest for one unit
    while (1) begin
      j = earliest_job();
      if (j < 0 || n >= MAX_RESULTS) break;
      if (job_due[j] < sched_now || job_due[j] - sched_now <= TIME_W'(job_left[j])) begin
        add_result(job_ident[j], OUT_DROPPED, '0, '0);
        job_live[j] = 1'b0;
        n++;
        continue;
      end
      if (job_left[j] != '0) job_left[j] = job_left[j] - 1'b1;
      if (job_left[j] == '0) begin
        ta    = sched_now + 1 - job_arrived[j];
        burst = TIME_W'(job_len[j]);
        add_result(job_ident[j], OUT_COMPLETED, ta, (ta >= burst) ? ta - burst : '0);
        job_live[j] = 1'b0;
        n++;
      end
      break;
    end
    sched_now = sched_now + 1;
    if (n > 0) pending_results[pending_results.size() - 1].last = 1'b1;
    return n;
  endfunction

  function automatic void add_row(logic req_type, logic [ID_W-1:0] id,
                                  logic [TIME_W-1:0] due, logic [BURST_W-1:0] len,
                                  bit typed = 1'b0, int exp_n = 0,
                                  logic [ID_W-1:0] exp_id = '0,
                                  outcome_e exp_outcome = OUT_DROPPED,
                                  logic [TIME_W-1:0] exp_time = '0);
    step_row_t row;
    row.req_type    = req_type;
    row.id          = id;
    row.due         = due;
    row.len         = len;
    row.typed       = typed;
    row.exp_n       = exp_n;
    row.exp_id      = exp_id;
    row.exp_outcome = exp_outcome;
    row.exp_time    = exp_time;
    directed_steps = {directed_steps, row};
  endfunction

  task automatic report_mismatch(string what, logic [TIME_W-1:0] got,
                                 logic [TIME_W-1:0] want);
    $display("%0t ns: %s mismatch: got %0h, expected %0h", $time, what, got, want);
    error_count++;
  endtask

  // offer one request from a falling edge, return once it is taken
  task automatic offer_request(input logic req_type, input logic [ID_W-1:0] id,
                               input logic [TIME_W-1:0] due,
                               input logic [BURST_W-1:0] len, output int n);
    while ($urandom_range(0, 99) < gap_pct) begin
      req_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_bus.valid        <= 1'b1;
    req_bus.req_type     <= req_type;
    req_bus.job_id       <= id;
    req_bus.job_deadline <= due;
    req_bus.job_burst    <= len;
    do @(posedge clk_i); while (!req_bus.ready);
    n = schedule_step(req_type, id, due, len);
  endtask

  // result checker
  always @(posedge clk_i) begin
    sched_result_t want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with none pending, res_id", res_bus.res_id, '0);
      end else begin
        want = pending_results.pop_front();
        if (res_bus.res_id !== want.id) report_mismatch("res_id", res_bus.res_id, want.id);
        if (res_bus.outcome !== want.outcome)
          report_mismatch("outcome", res_bus.outcome, want.outcome);
        if (res_bus.event_time !== want.event_time)
          report_mismatch("event_time", res_bus.event_time, want.event_time);
        if (res_bus.turnaround !== want.turnaround)
          report_mismatch("turnaround", res_bus.turnaround, want.turnaround);
        if (res_bus.wait_time !== want.wait_time)
          report_mismatch("wait_time", res_bus.wait_time, want.wait_time);
        if (res_bus.last !== want.last) report_mismatch("last", res_bus.last, want.last);
      end
    end
  end

  // watchdog on cycles with no handshake at all
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready))
      quiet_cycles <= 0;
    else if (rst_ni)
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result receiver: random stalls, plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left     = 0;
    res_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // request sender
  initial begin
    int                 n;
    step_row_t          row;
    sched_result_t      typed_result;
    logic               rtype;
    logic [ID_W-1:0]    rid;
    logic [TIME_W-1:0]  rdue;
    logic [BURST_W-1:0] rlen;
    int unsigned        tick_pct;
    int unsigned        pick;

    req_bus.valid        = 1'b0;
    req_bus.req_type     = REQ_ARRIVE;
    req_bus.job_id       = '0;
    req_bus.job_deadline = '0;
    req_bus.job_burst    = '0;
    for (int i = 0; i < JOB_SLOTS; i++) job_live[i] = 1'b0;
    sched_now = '0;
    tick_pct  = 50;

    // directed steps
    add_row(REQ_TICK, 16'h1234, '1, '1, 1'b1, 0);                 // empty table
    add_row(REQ_ARRIVE, 16'hFFFF, '0, 16'd1, 1'b1, 0);            // deadline passed
    add_row(REQ_TICK, '0, '0, '0, 1'b1, 1, 16'hFFFF, OUT_DROPPED, 32'd1);
    add_row(REQ_ARRIVE, 16'h0000, 32'hFFFF_FFFF, 16'hFFFF);       // far and long
    add_row(REQ_ARRIVE, 16'h0001, 32'd10, 16'd0);                 // zero burst, runs once
    add_row(REQ_TICK, 16'hA5A5, 32'h5A5A_5A5A, 16'h00FF);
    add_row(REQ_ARRIVE, 16'h0002, 32'd7, 16'd4);                  // slack equals burst
    add_row(REQ_ARRIVE, 16'h0003, 32'd3, 16'd0);                  // zero burst, due now
    add_row(REQ_TICK, 16'h5A5A, 32'hA5A5_A5A5, 16'hFF00);
    // fill the table with jobs that are all infeasible at the next tick
    for (int k = 0; k < JOB_SLOTS - 1; k++)
      add_row(REQ_ARRIVE, ID_W'(16'h0100 + k), TIME_W'(4 + k % 3), 16'd2);
    add_row(REQ_ARRIVE, 16'hBEEF, 32'h8000_0000, 16'h8000, 1'b1, 1, 16'hBEEF,
            OUT_REJECTED, 32'd4);
    add_row(REQ_TICK, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);        // mass drop

    // reset
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_steps[k]) begin
      row = directed_steps[k];
      offer_request(row.req_type, row.id, row.due, row.len, n);
      if (row.typed) begin
        // the hand-written result stands in for the modeled one
        repeat (n) void'(pending_results.pop_back());
        if (row.exp_n != 0) begin
          typed_result.id         = row.exp_id;
          typed_result.outcome    = row.exp_outcome;
          typed_result.event_time = row.exp_time;
          typed_result.turnaround = '0;
          typed_result.wait_time  = '0;
          typed_result.last       = 1'b1;
          pending_results = {pending_results, typed_result};
        end
      end
      @(negedge clk_i);
    end

    // random arrivals and ticks in arrival-heavy and tick-heavy runs
    for (int unsigned k = 0; k < RAND_ITEMS; k++) begin
      if (k % 20 == 0) tick_pct = $urandom_range(0, 1) ? 30 : 70;
      if (k == 60) begin
        // pause until every pending result is out
        req_bus.valid <= 1'b0;
        @(negedge clk_i);
        while (pending_results.size() != 0) @(negedge clk_i);
      end
      if (k == 100) hold_request = 1'b1;
      if (k == 140) begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      if (k == 200) begin
        gap_pct   = 13;
        stall_pct = 13;
      end
      rid  = ID_W'($urandom);
      rdue = $urandom;
      rlen = BURST_W'($urandom_range(1, 65535));
      if ($urandom_range(0, 99) < tick_pct) begin
        rtype = REQ_TICK;
      end else begin
        rtype = REQ_ARRIVE;
        pick  = $urandom_range(0, 99);
        if (pick < 8) begin
          // far deadline, short job
          rlen = BURST_W'($urandom_range(1, 8));
        end else if (pick < 18) begin
          // deadline already behind
          rdue = sched_now - $urandom_range(1, 8);
        end else if (pick < 30) begin
          // near deadline, long job: mostly infeasible
          rdue = sched_now + $urandom_range(0, 40);
        end else begin
          rdue = sched_now + $urandom_range(0, 40);
          rlen = BURST_W'($urandom_range(1, 8));
        end
      end
      offer_request(rtype, rid, rdue, rlen, n);
      @(negedge clk_i);
    end

    // drain and finish
    req_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

[edf_scheduler_with_drop_top.f]
rtl/edfsd_pkg.sv
rtl/edfsd_ifs.sv
rtl/edfsd_dp.sv
rtl/edfsd_ctrl.sv
rtl/edf_scheduler_with_drop_top.sv
rtl/edfsd_checker.sv
bench/edf_scheduler_with_drop_top_test.sv
